[src/acsm_pkg.sv]
`timescale 1ns / 1ps

package acsm_pkg;

  // Fixed field widths of the channels and the configuration port
  localparam int SAMPLE_W   = 10;
  localparam int POS_W      = 8;
  localparam int REM_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX    = 2'd2;

  // Reset values of the configuration registers
  localparam logic [POS_W-1:0] RST_CENTER = 8'd4;
  localparam logic [POS_W-1:0] RST_MIN    = 8'd0;
  localparam logic [POS_W-1:0] RST_MAX    = 8'd7;

  // Clamp window handed to the smoothing stage
  typedef struct packed {
    logic [POS_W-1:0] lo;
    logic [POS_W-1:0] hi;
  } bounds_t;

endpackage

[src/acsm_if.sv]
`timescale 1ns / 1ps

// Sample / command request channel
interface acsm_in_if;
  import acsm_pkg::*;

  logic                valid;
  logic                ready;
  logic                mode;
  logic [SAMPLE_W-1:0] sample_x;
  logic [SAMPLE_W-1:0] sample_y;
  logic [SAMPLE_W-1:0] sample_z;

  modport source (output valid, mode, sample_x, sample_y, sample_z, input ready);
  modport sink   (input valid, mode, sample_x, sample_y, sample_z, output ready);
endinterface

// Position result channel
interface acsm_out_if;
  import acsm_pkg::*;

  logic             valid;
  logic             ready;
  logic [POS_W-1:0] pos_x;
  logic [POS_W-1:0] pos_y;
  logic [REM_W-1:0] cal_remaining;

  modport source (output valid, pos_x, pos_y, cal_remaining, input ready);
  modport sink   (input valid, pos_x, pos_y, cal_remaining, output ready);
endinterface

[src/accel_calibrate_smooth_map.sv]
`timescale 1ns / 1ps

// Accelerometer zero calibration and smoothed display mapping.
// in_chan carries one request per item: mode 0 is a three-axis ADC sample,
// mode 1 restarts zero calibration. out_chan returns exactly one result per
// request: the X/Y display positions and the calibration samples still needed.
// The first CAL_SAMPLES samples after reset or a restart are averaged into
// zero offsets; the last of them and later samples move the positions
// (center + sample - zero, smoothed but for the last, clamped to [min, max]).
// cfg_we / cfg_index / cfg_wdata write display center, min and max; write
// them only while no request is in flight.
// A request passes through the registered stages input register,
// accumulate, offset divide, zero correction and smoothing.
// Throughput: one request per cycle while out_chan is ready; the position
// feedback closes inside the smoothing stage.
// Reset: center 4, min 0, max 7, positions 4, calibration pending.
// When out_chan stalls, the result holds and earlier stages keep filling
// their empty slots; in_chan.ready drops only once every stage is occupied.
module accel_calibrate_smooth_map #(
  parameter int CAL_SAMPLES   = 16,
  parameter int SMOOTH_WEIGHT = 3,
  parameter int ADC_BITS      = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  acsm_in_if.sink                           in_chan,
  acsm_out_if.source                        out_chan,
  input  logic                              cfg_we,
  input  logic [acsm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [acsm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import acsm_pkg::*;

  // Derived sizes
  localparam int SW      = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;
  localparam int SMAX    = (1 << SW) - 1;
  localparam int SUM_W   = $clog2(CAL_SAMPLES * SMAX + 1);
  localparam int CNT_W   = $clog2(CAL_SAMPLES + 1);
  localparam int POS_MAX = (1 << POS_W) - 1;
  localparam int V_W     = $clog2(POS_MAX + SMAX + 1) + 1;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAL_SAMPLES);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  // Sum / CAL_SAMPLES by reciprocal multiply, exact over the sum range
  localparam int DL     = $clog2(CAL_SAMPLES);
  localparam int DK     = SUM_W + DL;
  localparam int DM_W   = DK + 1;
  localparam longint unsigned DIV_M_L =
    ((64'd1 << DK) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
  localparam logic [DM_W-1:0] DIV_M  = DM_W'(DIV_M_L);
  localparam int PROD_W = SUM_W + DM_W;

  typedef struct packed {
    logic          mode;
    logic [SW-1:0] sx;
    logic [SW-1:0] sy;
  } req_t;

  typedef struct packed {
    logic             map;
    logic             skip;
    logic [CNT_W-1:0] cnt;
    logic [SW-1:0]    sx;
    logic [SW-1:0]    sy;
  } acc_t;

  typedef struct packed {
    logic                  map;
    logic                  skip;
    logic [CNT_W-1:0]      cnt;
    logic signed [V_W-1:0] vx;
    logic signed [V_W-1:0] vy;
  } corr_t;

  // Configuration registers
  logic [POS_W-1:0] center_r;
  logic [POS_W-1:0] min_r;
  logic [POS_W-1:0] max_r;

  // Calibration and position state
  logic [SUM_W-1:0] sum_r [2];
  logic [SUM_W-1:0] sum_nxt [2];
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [SW-1:0]    zero_r [2];
  logic [POS_W-1:0] pos_r [2];

  // Pipeline stages
  logic  v1_r, v2_r, v3_r, v4_r, out_valid_r;
  req_t  s1_r;
  acc_t  s2_r, s2_nxt;
  acc_t  s3_r;
  corr_t s4_r, s4_nxt;
  logic [POS_W-1:0] out_pos_x_r;
  logic [POS_W-1:0] out_pos_y_r;
  logic [REM_W-1:0] out_rem_r;

  logic rdy_out, rdy4, rdy3, rdy2, rdy1;
  logic in_fire, t12, t23, t34, t4o;

  logic [PROD_W-1:0] off_prod_x, off_prod_y;
  logic [SW-1:0]     off_x, off_y;
  logic [POS_W-1:0]  pos_x_new, pos_y_new;
  bounds_t           bnd;

  // Per-stage ready: a stage takes a request when empty or draining
  assign rdy_out = !out_valid_r || out_chan.ready;
  assign rdy4    = !v4_r || rdy_out;
  assign rdy3    = !v3_r || rdy4;
  assign rdy2    = !v2_r || rdy3;
  assign rdy1    = !v1_r || rdy2;

  assign in_fire = in_chan.valid && rdy1;
  assign t12     = v1_r && rdy2;
  assign t23     = v2_r && rdy3;
  assign t34     = v3_r && rdy4;
  assign t4o     = v4_r && rdy_out;

  assign in_chan.ready          = rdy1;
  assign out_chan.valid         = out_valid_r;
  assign out_chan.pos_x         = out_pos_x_r;
  assign out_chan.pos_y         = out_pos_y_r;
  assign out_chan.cal_remaining = out_rem_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r <= RST_CENTER;
      min_r    <= RST_MIN;
      max_r    <= RST_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CENTER: center_r <= cfg_wdata;
        CFG_MIN:    min_r    <= cfg_wdata;
        CFG_MAX:    max_r    <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire)  v1_r <= 1'b1;
      else if (t12) v1_r <= 1'b0;
      if (t12)      v2_r <= 1'b1;
      else if (t23) v2_r <= 1'b0;
      if (t23)      v3_r <= 1'b1;
      else if (t34) v3_r <= 1'b0;
      if (t34)      v4_r <= 1'b1;
      else if (t4o) v4_r <= 1'b0;
      if (t4o)      out_valid_r <= 1'b1;
      else if (out_chan.ready) out_valid_r <= 1'b0;
    end
  end

  // Capture the request; Z is not captured, since no result uses it
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r.mode <= in_chan.mode;
      s1_r.sx   <= in_chan.sample_x[SW-1:0];
      s1_r.sy   <= in_chan.sample_y[SW-1:0];
    end
  end

  // Accumulate calibration samples or restart calibration
  always_comb begin
    sum_nxt[0]  = sum_r[0];
    sum_nxt[1]  = sum_r[1];
    cnt_nxt     = cnt_r;
    s2_nxt.map  = 1'b0;
    s2_nxt.skip = 1'b0;
    s2_nxt.sx   = s1_r.sx;
    s2_nxt.sy   = s1_r.sy;
    if (s1_r.mode) begin
      sum_nxt[0] = '0;
      sum_nxt[1] = '0;
      cnt_nxt    = CNT_FULL;
    end else if (cnt_r != '0) begin
      sum_nxt[0] = sum_r[0] + SUM_W'(s1_r.sx);
      sum_nxt[1] = sum_r[1] + SUM_W'(s1_r.sy);
      cnt_nxt    = cnt_r - CNT_ONE;
      if (cnt_r == CNT_ONE) begin
        s2_nxt.map  = 1'b1;
        s2_nxt.skip = 1'b1;
      end
    end else begin
      s2_nxt.map = 1'b1;
    end
    s2_nxt.cnt = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r[0] <= '0;
      sum_r[1] <= '0;
      cnt_r    <= CNT_FULL;
    end else if (t12) begin
      sum_r[0] <= sum_nxt[0];
      sum_r[1] <= sum_nxt[1];
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (t12) s2_r <= s2_nxt;
  end

  // Average the sums into zero offsets when calibration completes
  always_comb begin
    off_prod_x = PROD_W'(sum_r[0]) * PROD_W'(DIV_M);
    off_prod_y = PROD_W'(sum_r[1]) * PROD_W'(DIV_M);
    off_x      = off_prod_x[DK +: SW];
    off_y      = off_prod_y[DK +: SW];
  end

  always_ff @(posedge clk) begin
    if (t23) begin
      s3_r <= s2_r;
      if (s2_r.skip) begin
        zero_r[0] <= off_x;
        zero_r[1] <= off_y;
      end
    end
  end

  // Zero-correct around the display center
  always_comb begin
    s4_nxt.map  = s3_r.map;
    s4_nxt.skip = s3_r.skip;
    s4_nxt.cnt  = s3_r.cnt;
    s4_nxt.vx   = $signed(V_W'(center_r)) + $signed(V_W'(s3_r.sx))
                  - $signed(V_W'(zero_r[0]));
    s4_nxt.vy   = $signed(V_W'(center_r)) + $signed(V_W'(s3_r.sy))
                  - $signed(V_W'(zero_r[1]));
  end

  always_ff @(posedge clk) begin
    if (t34) s4_r <= s4_nxt;
  end

  // Smooth and clamp each axis against its current position
  assign bnd = '{lo: min_r, hi: max_r};

  acsm_smooth #(
    .SMOOTH_WEIGHT (SMOOTH_WEIGHT),
    .V_W           (V_W)
  ) u_smooth_x (
    .pos     (pos_r[0]),
    .v       (s4_r.vx),
    .skip    (s4_r.skip),
    .bounds  (bnd),
    .pos_new (pos_x_new)
  );

  acsm_smooth #(
    .SMOOTH_WEIGHT (SMOOTH_WEIGHT),
    .V_W           (V_W)
  ) u_smooth_y (
    .pos     (pos_r[1]),
    .v       (s4_r.vy),
    .skip    (s4_r.skip),
    .bounds  (bnd),
    .pos_new (pos_y_new)
  );

  // Update positions and load the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r[0] <= RST_CENTER;
      pos_r[1] <= RST_CENTER;
    end else if (t4o && s4_r.map) begin
      pos_r[0] <= pos_x_new;
      pos_r[1] <= pos_y_new;
    end
  end

  always_ff @(posedge clk) begin
    if (t4o) begin
      out_pos_x_r <= s4_r.map ? pos_x_new : pos_r[0];
      out_pos_y_r <= s4_r.map ? pos_y_new : pos_r[1];
      out_rem_r   <= REM_W'(s4_r.cnt);
    end
  end

`ifndef SYNTHESIS
  // Running X sum never exceeds the samples taken times full scale
  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(sum_r[0]) <= (32'(CAL_SAMPLES) - 32'(cnt_r)) * 32'(SMAX))
    else $error("calibration sum exceeds sample count bound");

  // A mapped request only exists once calibration is complete
  a_map_done: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && s4_r.map) |-> (s4_r.cnt == '0))
    else $error("position update while calibration pending");

  // With an ordered window, a new position stays inside it
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (t4o && s4_r.map && (min_r <= max_r)) |->
      (pos_x_new >= min_r && pos_x_new <= max_r &&
       pos_y_new >= min_r && pos_y_new <= max_r))
    else $error("position outside clamp window");
`endif

endmodule

[src/acsm_smooth.sv]
`timescale 1ns / 1ps

// One axis: weighted average against the previous position unless bypassed, then clamp.
module acsm_smooth #(
  parameter int SMOOTH_WEIGHT = 3,
  parameter int V_W           = 12
) (
  input  logic [acsm_pkg::POS_W-1:0] pos,
  input  logic signed [V_W-1:0]      v,
  input  logic                       skip,
  input  acsm_pkg::bounds_t          bounds,
  output logic [acsm_pkg::POS_W-1:0] pos_new
);
  import acsm_pkg::*;

  // Magnitude bound of prev * weight + v
  localparam int POS_MAX = (1 << POS_W) - 1;
  localparam int T_MAX   = POS_MAX * SMOOTH_WEIGHT + (1 << (V_W - 1));
  localparam int TM_W    = $clog2(T_MAX + 1);
  localparam int T_W     = TM_W + 1;

  // Reciprocal of the divisor, exact for every TM_W-bit dividend
  localparam int DIVISOR = SMOOTH_WEIGHT + 1;
  localparam int DL      = $clog2(DIVISOR);
  localparam int DK      = TM_W + DL;
  localparam int DM_W    = DK + 1;
  localparam longint unsigned DIV_M_L =
    ((64'd1 << DK) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [DM_W-1:0] DIV_M  = DM_W'(DIV_M_L);
  localparam int PROD_W = TM_W + DM_W;

  logic [TM_W-1:0]        prev_w;
  logic signed [T_W-1:0]  t;
  logic                   t_neg;
  logic [TM_W-1:0]        t_mag;
  logic [PROD_W-1:0]      q_prod;
  logic [TM_W-1:0]        q_mag;
  logic signed [T_W-1:0]  q;
  logic signed [T_W-1:0]  s;
  logic signed [T_W-1:0]  lo_s;
  logic signed [T_W-1:0]  hi_s;

  // Weighted sum, kept signed
  assign prev_w = TM_W'(pos) * TM_W'(SMOOTH_WEIGHT);
  assign t      = $signed({1'b0, prev_w}) + T_W'(v);

  // Divide the magnitude, then restore the sign (truncate toward zero)
  always_comb begin
    t_neg  = t[T_W-1];
    t_mag  = TM_W'(t_neg ? -t : t);
    q_prod = PROD_W'(t_mag) * PROD_W'(DIV_M);
    q_mag  = q_prod[DK +: TM_W];
    q      = t_neg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
  end

  // Bypass smoothing on the first update after calibration, then clamp
  always_comb begin
    s    = skip ? T_W'(v) : q;
    lo_s = $signed(T_W'(bounds.lo));
    hi_s = $signed(T_W'(bounds.hi));
    if (s < lo_s) begin
      pos_new = bounds.lo;
    end else if (s > hi_s) begin
      pos_new = bounds.hi;
    end else begin
      pos_new = s[POS_W-1:0];
    end
  end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

package tb_pos_pkg;
  import acsm_pkg::*;

  localparam int CAL_N    = 16;
  localparam int SMOOTH_W = 3;

  typedef struct packed {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [REM_W-1:0] remaining;
  } pos_result_t;

  // Tracks calibration and display positions, queues the result of each request
  class pos_tracker;
    logic [POS_W-1:0]    center;
    logic [POS_W-1:0]    lo;
    logic [POS_W-1:0]    hi;
    logic [13:0]         zero_acc[3];
    logic [SAMPLE_W-1:0] zero_off[3];
    logic [POS_W-1:0]    pos[2];
    int                  left;
    bit                  skip;
    pos_result_t         pending[$];
    int                  errors;
    int                  checked;

    function new();
      center = RST_CENTER;
      lo     = RST_MIN;
      hi     = RST_MAX;
      for (int i = 0; i < 3; i++) begin
        zero_acc[i] = '0;
        zero_off[i] = '0;
      end
      pos[0]  = RST_CENTER;
      pos[1]  = RST_CENTER;
      left    = CAL_N;
      skip    = 1'b0;
      errors  = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_CENTER: center = val;
        CFG_MIN:    lo = val;
        CFG_MAX:    hi = val;
        default: ;
      endcase
    endfunction

    // Zero-correct, optionally smooth against the previous position, then clamp
    function logic [POS_W-1:0] smooth_axis(logic [POS_W-1:0] prev,
                                           logic [SAMPLE_W-1:0] s,
                                           logic [SAMPLE_W-1:0] zero);
      int v;
      int sv;
      int zv;
      int p;
      int lo_i;
      int hi_i;
      v    = int'(center);
      sv   = int'(s);
      zv   = int'(zero);
      p    = int'(prev);
      lo_i = int'(lo);
      hi_i = int'(hi);
      v = v + sv - zv;
      if (!skip) v = (p * SMOOTH_W + v) / (SMOOTH_W + 1);
      // floor test wins when the bounds are crossed
      if (v < lo_i) v = lo_i;
      else if (v > hi_i) v = hi_i;
      return v[POS_W-1:0];
    endfunction

    function void take_request(logic m, logic [SAMPLE_W-1:0] x,
                               logic [SAMPLE_W-1:0] y, logic [SAMPLE_W-1:0] z);
      logic [SAMPLE_W-1:0] s[3];
      pos_result_t r;
      s[0] = x;
      s[1] = y;
      s[2] = z;
      if (m) begin
        // restart: clear sums, keep offsets and positions
        for (int i = 0; i < 3; i++) zero_acc[i] = '0;
        left = CAL_N;
      end else begin
        if (left != 0) begin
          for (int i = 0; i < 3; i++) zero_acc[i] = zero_acc[i] + s[i];
          left--;
          if (left == 0) begin
            for (int i = 0; i < 3; i++) zero_off[i] = SAMPLE_W'(zero_acc[i] / CAL_N);
            skip = 1'b1;
          end
        end
        // the sample that completes calibration is mapped too
        if (left == 0) begin
          pos[0] = smooth_axis(pos[0], s[0], zero_off[0]);
          pos[1] = smooth_axis(pos[1], s[1], zero_off[1]);
          skip   = 1'b0;
        end
      end
      r.pos_x     = pos[0];
      r.pos_y     = pos[1];
      r.remaining = left[REM_W-1:0];
      pending.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, want, checked);
    endtask

    task match_result(logic [POS_W-1:0] px, logic [POS_W-1:0] py, logic [REM_W-1:0] rem);
      pos_result_t want;
      if (pending.size() == 0) begin
        report("result with no pending request", 32'(px), 32'd0);
      end else begin
        want = pending.pop_front();
        checked++;
        if (px !== want.pos_x) report("pos_x", 32'(px), 32'(want.pos_x));
        if (py !== want.pos_y) report("pos_y", 32'(py), 32'(want.pos_y));
        if (rem !== want.remaining)
          report("cal_remaining", 32'(rem), 32'(want.remaining));
      end
    endtask
  endclass

endpackage

module tb_top;
  import acsm_pkg::*;
  import tb_pos_pkg::*;

  localparam int IDLE_LIMIT      = 1000;
  localparam int DRAIN_CYCLES    = 10;
  localparam int ITEMS_PER_PHASE = 165;
  localparam int NUM_TABLE       = 7;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  acsm_in_if  in_if();
  acsm_out_if out_if();

  accel_calibrate_smooth_map #(
    .CAL_SAMPLES  (CAL_N),
    .SMOOTH_WEIGHT(SMOOTH_W),
    .ADC_BITS     (SAMPLE_W)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  pos_tracker trk;
  bit calm;
  int sent;
  int restarts;
  int settings;
  int idle_cycles;
  int bases[3];

  // center, min, max for each table-driven random phase; crossed bounds included
  int phase_cfg[NUM_TABLE][3] = '{
    '{128, 0, 255}, '{0, 0, 255}, '{255, 0, 255}, '{100, 200, 50},
    '{0, 0, 0}, '{255, 255, 255}, '{128, 120, 136}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, a few long ones; none in calm phases
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Jitter around the axis base, with occasional full-range values
  function automatic logic [SAMPLE_W-1:0] draw_axis(int base);
    int v;
    if ($urandom_range(0, 9) == 0) return SAMPLE_W'($urandom);
    v = base + $urandom_range(0, 48) - 24;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return v[SAMPLE_W-1:0];
  endfunction

  // Present one request and hold it until accepted
  task send_req(input logic m, input logic [SAMPLE_W-1:0] x,
                input logic [SAMPLE_W-1:0] y, input logic [SAMPLE_W-1:0] z);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.mode     <= m;
    in_if.sample_x <= x;
    in_if.sample_y <= y;
    in_if.sample_z <= z;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
    trk.take_request(m, x, y, z);
    sent++;
    if (m) restarts++;
  endtask

  task restart_cal();
    for (int i = 0; i < 3; i++) bases[i] = $urandom_range(0, 1023);
    send_req(1'b1, SAMPLE_W'($urandom), SAMPLE_W'($urandom), SAMPLE_W'($urandom));
  endtask

  // Drop valid and wait until every pending result has come back
  task settle();
    in_if.valid <= 1'b0;
    while (trk.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task write_regs(input logic [7:0] c, input logic [7:0] lo, input logic [7:0] hi);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CENTER;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_index <= CFG_MIN;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_index <= CFG_MAX;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_we <= 1'b0;
    trk.set_reg(CFG_CENTER, c);
    trk.set_reg(CFG_MIN, lo);
    trk.set_reg(CFG_MAX, hi);
    settings++;
  endtask

  task random_phase(input bit with_restart);
    if (with_restart) restart_cal();
    for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
      if ($urandom_range(0, 99) < 2) restart_cal();
      else send_req(1'b0, draw_axis(bases[0]), draw_axis(bases[1]), draw_axis(bases[2]));
    end
  endtask

  // Result side: random stalls on ready
  initial begin
    int stall;
    out_if.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = idle_len();
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      trk.match_result(out_if.pos_x, out_if.pos_y, out_if.cal_remaining);
  end

  // Abort when no request moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles", IDLE_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    trk         = new();
    calm        = 1'b0;
    sent        = 0;
    restarts    = 0;
    settings    = 1;
    rst_n          <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.mode     <= 1'b0;
    in_if.sample_x <= '0;
    in_if.sample_y <= '0;
    in_if.sample_z <= '0;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_CENTER;
    cfg_wdata      <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: restart before any sample, partial calibration, restart again
    send_req(1'b1, 10'd1023, 10'd1023, 10'd1023);
    send_req(1'b0, 10'd1023, 10'd0, 10'd1023);
    send_req(1'b0, 10'd0, 10'd1023, 10'd0);
    send_req(1'b0, 10'd512, 10'd511, 10'd1023);
    send_req(1'b1, 10'd0, 10'd0, 10'd0);
    // Full calibration with extreme samples; the last one is mapped unsmoothed
    for (int i = 0; i < CAL_N; i++)
      send_req(1'b0, (i % 2) ? 10'd1023 : 10'd0, 10'd1023, SAMPLE_W'(i * 60));
    // Mapped samples: above ceiling, below floor, near center
    send_req(1'b0, 10'd1023, 10'd0, 10'd512);
    send_req(1'b0, 10'd0, 10'd1023, 10'd0);
    send_req(1'b0, 10'd511, 10'd1023, 10'd0);
    send_req(1'b0, 10'd515, 10'd1022, 10'd1023);

    // Random under reset settings
    for (int i = 0; i < 3; i++) bases[i] = $urandom_range(0, 1023);
    random_phase(1'b1);
    settle();

    // Random under each table setting, then one random setting
    for (int ph = 0; ph <= NUM_TABLE; ph++) begin
      calm = (ph % 3 == 2);
      if (ph < NUM_TABLE)
        write_regs(8'(phase_cfg[ph][0]), 8'(phase_cfg[ph][1]), 8'(phase_cfg[ph][2]));
      else
        write_regs(8'($urandom), 8'($urandom), 8'($urandom));
      random_phase(ph % 2 == 1);
      settle();
    end

    $display("Sent %0d requests (%0d calibration restarts) over %0d register settings",
             sent, restarts, settings);
    $display("Checked %0d results, %0d mismatches", trk.checked, trk.errors);
    if (trk.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
